@@ hw/rtl/ffa_pkg.sv @@
// Shared types and codes for the first-fit free-list allocator.
// No dependencies; imported by the allocator top level.
package ffa_pkg;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_AWALK,
    S_ASCAN,
    S_WPREV,
    S_WCUR,
    S_HCHECK,
    S_RWALK,
    S_RESP
  } state_t;

  localparam logic [1:0] CMD_ALLOC   = 2'd0;
  localparam logic [1:0] CMD_RELEASE = 2'd1;
  localparam logic [1:0] CMD_ADDREF  = 2'd2;
  localparam logic [1:0] CMD_INIT    = 2'd3;

  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_BAD     = 3'd1;
  localparam logic [2:0] ST_NOFIT   = 3'd2;
  localparam logic [2:0] ST_NOSPARE = 3'd3;
  localparam logic [2:0] ST_DOUBLE  = 3'd4;
  localparam logic [2:0] ST_FREE    = 3'd5;

  localparam logic [3:0] CFG_ALIGN_LOG2  = 4'd0;
  localparam logic [3:0] CFG_BUFFER_SIZE = 4'd1;

  localparam int REF_W = 16;
  localparam logic [REF_W-1:0] REF_MAX = '1;

endpackage

@@ hw/rtl/ffa_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies; holds the allocator's descriptor table.
module ffa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ hw/rtl/first_fit_free_list_allocator.sv @@
// First-fit free-list allocator: top level with sequencer and list walker.
// Depends on ffa_pkg and ffa_ram (descriptor table).
//
// Manages a byte buffer through a table of MAX_BLOCKS descriptors kept in one
// RAM (one write and one registered read per cycle); the free list is linked
// through that RAM in offset order. One command is in flight at a time and
// in_ready is high only while the sequencer is idle. Each list step reads one
// descriptor per cycle through the RAM read port; the steps of each command:
//   allocate    : walk the list to the first free block that fits; on a
//                 split, scan for the lowest unused descriptor for the
//                 remainder; then write the previous link and the block.
//                 Each walk covers at most MAX_BLOCKS entries; a zero or
//                 oversized request is answered without a walk.
//   release     : decrement the count; when it reaches zero, walk the list
//                 and link the block in (no linking when it is listed).
//   add ref     : increment the count.
//   reinit      : clearing pass over the table.
// The response cycle stalls while the output register still holds a result
// that has not been taken.
// After reset the same clearing pass runs; no command is taken then, but
// configuration writes are. The result sits in an output
// register, so the next command may be taken while it waits for transfer.
// Configuration (cfg_index 0: alignment log2, 1: buffer length in bytes) is
// always ready and should only be written while the block is idle.
module first_fit_free_list_allocator #(
  parameter int MAX_BLOCKS  = 64,
  parameter int OFFSET_BITS = 32
) (
  input  logic        clk,
  input  logic        rst,
  // command channel
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  command,
  input  logic [31:0] request_size,
  input  logic [5:0]  block_handle,
  // result channel
  output logic        out_valid,
  input  logic        out_ready,
  output logic [5:0]  result_handle,
  output logic [31:0] block_offset,
  output logic [2:0]  status,
  // configuration writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [3:0]  cfg_index,
  input  logic [31:0] cfg_data
);
  import ffa_pkg::*;

  localparam int IW  = $clog2(MAX_BLOCKS);      // table index
  localparam int LW  = $clog2(MAX_BLOCKS + 1);  // link, with null
  localparam int SW  = $clog2(MAX_BLOCKS + 1);  // walk step count
  localparam int OB  = OFFSET_BITS;
  localparam int SZW = (OB + 1 > 34) ? OB + 1 : 34;  // rounded size, no wrap

  localparam logic [LW-1:0] NULL_LINK = LW'(MAX_BLOCKS);
  localparam logic [IW-1:0] LAST_IDX  = IW'(MAX_BLOCKS - 1);
  localparam logic [SW-1:0] STEP_MAX  = SW'(MAX_BLOCKS);

  typedef struct packed {
    logic             in_use;
    logic             free;
    logic [REF_W-1:0] refs;
    logic [LW-1:0]    link;
    logic [OB-1:0]    start;
    logic [OB-1:0]    len;
  } desc_t;

  // configuration
  logic [4:0]  align_log2;
  logic [31:0] buf_bytes;

  // sequencer registers
  state_t         state, state_next;
  logic [1:0]     cmd_q, cmd_next;
  logic [5:0]     handle_q, handle_next;
  logic [OB-1:0]  size, size_next;
  logic [LW-1:0]  head, head_next;
  logic [LW-1:0]  cur, cur_next;
  logic [LW-1:0]  prev, prev_next;
  desc_t          prev_d, prev_d_next;
  logic [SW-1:0]  steps, steps_next;
  logic [IW-1:0]  scan, scan_next;
  logic [IW-1:0]  clr, clr_next;
  logic [LW-1:0]  newlink, newlink_next;
  logic [IW-1:0]  fin_addr, fin_addr_next;
  desc_t          fin_d, fin_d_next;
  desc_t          spare_d, spare_d_next;
  logic           init_pend, init_pend_next;
  logic [5:0]     res_handle, res_handle_next;
  logic [31:0]    res_offset, res_offset_next;
  logic [2:0]     res_status, res_status_next;

  // descriptor RAM
  logic           ram_we;
  logic [IW-1:0]  ram_waddr, ram_raddr;
  desc_t          ram_wdata, rd;

  ffa_ram #(
    .WIDTH($bits(desc_t)),
    .DEPTH(MAX_BLOCKS)
  ) u_desc_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (rd)
  );

  // shared conditions
  logic [SZW-1:0] amask, size_full;
  logic           oversize, h_ok, cur_valid, cur_ok, fit, exact, rel_go, in_xfer;
  logic           out_free, clr_last, scan_last;
  logic [IW-1:0]  hidx_q;
  desc_t          clr_d;

  assign amask     = (SZW'(1) << align_log2) - SZW'(1);
  assign size_full = (SZW'(request_size) + amask) & ~amask;
  assign oversize  = (size_full >> OB) != '0;
  assign h_ok      = 32'(block_handle) < 32'(MAX_BLOCKS);
  assign hidx_q    = IW'(handle_q);
  assign cur_valid = cur < NULL_LINK;
  assign cur_ok    = cur_valid && (steps != STEP_MAX);
  assign fit       = rd.free && (rd.len >= size);
  assign exact     = rd.len == size;
  assign rel_go    = cur_ok && (rd.start < fin_d.start);
  assign in_ready  = state == S_IDLE;
  assign in_xfer   = in_valid && in_ready;
  assign out_free  = !out_valid || out_ready;
  assign clr_last  = clr == LAST_IDX;
  assign scan_last = scan == LAST_IDX;
  assign cfg_ready = 1'b1;

  always_comb begin
    clr_d = '0;
    clr_d.link = NULL_LINK;
    if (clr == '0) begin
      clr_d.len    = OB'(buf_bytes);
      clr_d.free   = 1'b1;
      clr_d.in_use = 1'b1;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR: begin
        if (clr_last) state_next = init_pend ? S_RESP : S_IDLE;
      end
      S_IDLE: begin
        if (in_xfer) begin
          unique case (command)
            CMD_ALLOC:   state_next = (request_size == '0 || oversize) ? S_RESP : S_AWALK;
            CMD_INIT:    state_next = S_CLEAR;
            CMD_RELEASE,
            CMD_ADDREF:  state_next = h_ok ? S_HCHECK : S_RESP;
            default:     state_next = S_RESP;
          endcase
        end
      end
      S_AWALK: begin
        if (!cur_ok) state_next = S_RESP;
        else if (fit) state_next = exact ? S_WPREV : S_ASCAN;
      end
      S_ASCAN: begin
        if (!rd.in_use) state_next = S_WPREV;
        else if (scan_last) state_next = S_RESP;
      end
      S_WPREV: state_next = S_WCUR;
      S_WCUR:  state_next = S_RESP;
      S_HCHECK: begin
        if (cmd_q == CMD_RELEASE && rd.refs == REF_W'(1) && !rd.free) state_next = S_RWALK;
        else state_next = S_RESP;
      end
      S_RWALK: begin
        if (!rel_go) state_next = (cur == LW'(handle_q)) ? S_RESP : S_WPREV;
      end
      S_RESP: begin
        if (out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // datapath, RAM controls and result staging
  always_comb begin
    ram_we          = 1'b0;
    ram_waddr       = fin_addr;
    ram_wdata       = fin_d;
    ram_raddr       = '0;
    cmd_next        = cmd_q;
    handle_next     = handle_q;
    size_next       = size;
    head_next       = head;
    cur_next        = cur;
    prev_next       = prev;
    prev_d_next     = prev_d;
    steps_next      = steps;
    scan_next       = scan;
    clr_next        = clr;
    newlink_next    = newlink;
    fin_addr_next   = fin_addr;
    fin_d_next      = fin_d;
    spare_d_next    = spare_d;
    init_pend_next  = init_pend;
    res_handle_next = res_handle;
    res_offset_next = res_offset;
    res_status_next = res_status;
    unique case (state)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr;
        ram_wdata = clr_d;
        clr_next  = clr + IW'(1);
        head_next = '0;
        res_handle_next = '0;
        res_offset_next = '0;
        res_status_next = ST_OK;
      end
      S_IDLE: begin
        if (in_xfer) begin
          cmd_next        = command;
          handle_next     = block_handle;
          size_next       = OB'(size_full);
          cur_next        = head;
          prev_next       = NULL_LINK;
          steps_next      = '0;
          res_handle_next = '0;
          res_offset_next = '0;
          res_status_next = ST_OK;
          unique case (command)
            CMD_ALLOC: begin
              ram_raddr = IW'(head);
              if (request_size == '0) res_status_next = ST_BAD;
              else if (oversize) res_status_next = ST_NOFIT;
            end
            CMD_INIT: begin
              clr_next       = '0;
              init_pend_next = 1'b1;
            end
            default: begin
              ram_raddr       = IW'(block_handle);
              res_handle_next = block_handle;
              if (!h_ok) res_status_next = ST_BAD;
            end
          endcase
        end
      end
      S_AWALK: begin
        if (!cur_ok) begin
          res_status_next = ST_NOFIT;
        end else if (fit) begin
          fin_addr_next   = IW'(cur);
          fin_d_next      = rd;
          fin_d_next.link = NULL_LINK;
          fin_d_next.free = 1'b0;
          fin_d_next.refs = REF_W'(1);
          fin_d_next.len  = size;
          spare_d_next        = rd;
          spare_d_next.in_use = 1'b1;
          spare_d_next.free   = 1'b1;
          spare_d_next.refs   = '0;
          spare_d_next.start  = rd.start + size;
          spare_d_next.len    = rd.len - size;
          newlink_next    = rd.link;
          res_handle_next = 6'(cur);
          res_offset_next = 32'(rd.start);
          scan_next       = '0;
        end else begin
          prev_next   = cur;
          prev_d_next = rd;
          cur_next    = rd.link;
          ram_raddr   = IW'(rd.link);
          steps_next  = steps + SW'(1);
        end
      end
      S_ASCAN: begin
        if (!rd.in_use) begin
          // lowest unused descriptor takes the remainder
          ram_we       = 1'b1;
          ram_waddr    = scan;
          ram_wdata    = spare_d;
          newlink_next = LW'(scan);
        end else if (scan_last) begin
          res_handle_next = '0;
          res_offset_next = '0;
          res_status_next = ST_NOSPARE;
        end else begin
          scan_next = scan + IW'(1);
          ram_raddr = scan + IW'(1);
        end
      end
      S_WPREV: begin
        if (prev < NULL_LINK) begin
          ram_we         = 1'b1;
          ram_waddr      = IW'(prev);
          ram_wdata      = prev_d;
          ram_wdata.link = newlink;
        end else begin
          head_next = newlink;
        end
      end
      S_WCUR: begin
        ram_we = 1'b1;
      end
      S_HCHECK: begin
        res_offset_next = 32'(rd.start);
        ram_waddr       = hidx_q;
        ram_wdata       = rd;
        if (rd.refs == '0) begin
          res_status_next = (cmd_q == CMD_RELEASE) ? ST_DOUBLE : ST_FREE;
        end else if (cmd_q == CMD_ADDREF) begin
          if (rd.refs == REF_MAX) begin
            res_status_next = ST_BAD;
          end else begin
            ram_we         = 1'b1;
            ram_wdata.refs = rd.refs + REF_W'(1);
          end
        end else begin
          ram_wdata.refs = rd.refs - REF_W'(1);
          if (rd.refs != REF_W'(1)) begin
            ram_we = 1'b1;
          end else if (rd.free) begin
            ram_we          = 1'b1;
            res_status_next = ST_FREE;
          end else begin
            // last reference gone: walk the list for the insertion point
            fin_addr_next   = hidx_q;
            fin_d_next      = rd;
            fin_d_next.refs = '0;
            ram_raddr       = IW'(head);
          end
        end
      end
      S_RWALK: begin
        if (rel_go) begin
          prev_next   = cur;
          prev_d_next = rd;
          cur_next    = rd.link;
          ram_raddr   = IW'(rd.link);
          steps_next  = steps + SW'(1);
        end else if (cur == LW'(handle_q)) begin
          ram_we          = 1'b1;
          res_status_next = ST_FREE;
        end else begin
          fin_d_next.link = cur_valid ? cur : NULL_LINK;
          fin_d_next.free = 1'b1;
          newlink_next    = LW'(handle_q);
        end
      end
      S_RESP: begin
        init_pend_next = 1'b0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      clr        <= '0;
      init_pend  <= 1'b0;
      head       <= '0;
      out_valid  <= 1'b0;
      align_log2 <= 5'd3;
      buf_bytes  <= 32'd65536;
    end else begin
      state     <= state_next;
      clr       <= clr_next;
      init_pend <= init_pend_next;
      head      <= head_next;
      if (state == S_RESP && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (cfg_valid && cfg_ready) begin
        priority case (cfg_index)
          CFG_ALIGN_LOG2:  align_log2 <= cfg_data[4:0];
          CFG_BUFFER_SIZE: buf_bytes  <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    cmd_q      <= cmd_next;
    handle_q   <= handle_next;
    size       <= size_next;
    cur        <= cur_next;
    prev       <= prev_next;
    prev_d     <= prev_d_next;
    steps      <= steps_next;
    scan       <= scan_next;
    newlink    <= newlink_next;
    fin_addr   <= fin_addr_next;
    fin_d      <= fin_d_next;
    spare_d    <= spare_d_next;
    res_handle <= res_handle_next;
    res_offset <= res_offset_next;
    res_status <= res_status_next;
    if (state == S_RESP && out_free) begin
      result_handle <= res_handle;
      block_offset  <= res_offset;
      status        <= res_status;
    end
  end

`ifndef SYNTHESIS
  a_idle_no_write: assert property (@(posedge clk) disable iff (rst)
    state == S_IDLE |-> !ram_we)
    else $error("descriptor write while idle");

  a_head_in_range: assert property (@(posedge clk) disable iff (rst)
    head <= NULL_LINK)
    else $error("list head out of range");

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    in_xfer |=> state != S_IDLE)
    else $error("command transfer did not start work");
`endif

endmodule
